// File: src/uera_pkg.sv
// shared types and constants of the echo range averager
package uera_pkg;

  // field widths
  localparam int DIST_W   = 18;
  localparam int CNT_W    = 8;
  localparam int SUM_W    = 26;

  // speed of sound as 0.0343 cm/us in 1/256 cm, after halving the round trip
  localparam int          SPEED_W      = 12;
  localparam int          SPEED_SHIFT  = 8;
  localparam logic [SPEED_W-1:0] SPEED_FACTOR = 12'd2248;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT    = 2'd0,
    CFG_MIN_DISTANCE    = 2'd1,
    CFG_MAX_DISTANCE    = 2'd2,
    CFG_OFFSET_DISTANCE = 2'd3
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0]  RST_SAMPLE_COUNT    = 8'd1;
  localparam logic [DIST_W-1:0] RST_MIN_DISTANCE    = 18'd5120;
  localparam logic [DIST_W-1:0] RST_MAX_DISTANCE    = 18'd153600;
  localparam logic [DIST_W-1:0] RST_OFFSET_DISTANCE = 18'd0;

  // one finished batch handed from the front to the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] valid_cnt;
    logic [CNT_W-1:0] err_cnt;
  } batch_t;

  // divider sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } div_state_t;

endpackage

// File: src/uera_front.sv
// front end: echo width to distance, range checks and batch accumulation
module uera_front #(
  parameter int ECHO_WIDTH_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ECHO_WIDTH_BITS-1:0]   in_echo_width,
  input  logic                         in_echo_seen,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [uera_pkg::CNT_W-1:0]   sample_count,
  input  logic [uera_pkg::DIST_W-1:0]  min_distance,
  input  logic [uera_pkg::DIST_W-1:0]  max_distance,
  input  logic [uera_pkg::DIST_W-1:0]  offset_distance,
  output uera_pkg::batch_t             batch,
  output logic                         batch_push,
  input  logic                         q_full
);
  import uera_pkg::*;

  localparam int HALF_W = ECHO_WIDTH_BITS - 1;
  localparam int PROD_W = HALF_W + SPEED_W;
  localparam int DW     = PROD_W - SPEED_SHIFT;
  localparam int CMP_W  = (DW > DIST_W) ? DW : DIST_W;

  logic              s1_valid_r, s1_valid_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              seen_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  taken_r, taken_nxt;
  logic [CNT_W-1:0]  err_r, err_nxt;

  logic              accept, advance, stall;
  logic [DW-1:0]     raw_dist;
  logic [CMP_W-1:0]  dist_c, min_c, max_c, off_c, adj;
  logic              off_on, ok, batch_end;
  logic [SUM_W-1:0]  add, sum_new;
  logic [CNT_W-1:0]  err_new, taken_new;

  // stage one: halve the width and scale by the speed factor
  assign accept   = in_push && !in_full;
  assign prod_nxt = PROD_W'(in_echo_width[ECHO_WIDTH_BITS-1:1]) * PROD_W'(SPEED_FACTOR);

  // stage two: classify the sample and fold it into the batch
  always_comb begin
    raw_dist  = prod_r[PROD_W-1:SPEED_SHIFT];
    dist_c    = CMP_W'(raw_dist);
    min_c     = CMP_W'(min_distance);
    max_c     = CMP_W'(max_distance);
    off_c     = CMP_W'(offset_distance);
    off_on    = (offset_distance != '0);
    ok        = seen_r && (dist_c >= min_c) && (dist_c <= max_c)
                && !(off_on && (dist_c <= off_c));
    adj       = off_on ? (dist_c - off_c) : dist_c;
    add       = ok ? SUM_W'(adj) : '0;
    sum_new   = sum_r + add;
    err_new   = err_r + CNT_W'(!ok);
    taken_new = taken_r + CNT_W'(1);
    batch_end = (taken_new >= sample_count) || (taken_new == '0);
  end

  // a finished batch waits in stage two while the queue is full
  assign stall      = s1_valid_r && batch_end && q_full;
  assign advance    = s1_valid_r && !stall;
  assign in_full    = stall;
  assign batch_push = advance && batch_end;

  always_comb begin
    batch.sum       = sum_new;
    batch.valid_cnt = taken_new - err_new;
    batch.err_cnt   = err_new;
  end

  // next state of the batch counters
  always_comb begin
    s1_valid_nxt = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    sum_nxt      = sum_r;
    taken_nxt    = taken_r;
    err_nxt      = err_r;
    if (advance) begin
      if (batch_end) begin
        sum_nxt   = '0;
        taken_nxt = '0;
        err_nxt   = '0;
      end else begin
        sum_nxt   = sum_new;
        taken_nxt = taken_new;
        err_nxt   = err_new;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      sum_r      <= '0;
      taken_r    <= '0;
      err_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      sum_r      <= sum_nxt;
      taken_r    <= taken_nxt;
      err_r      <= err_nxt;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= prod_nxt;
      seen_r <= in_echo_seen;
    end
  end

  // a pushed batch leaves the counters clear
  a_batch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    batch_push |=> (taken_r == '0) && (err_r == '0) && (sum_r == '0))
    else $error("batch counters not cleared after push");

  // stalling only happens with a batch waiting on a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> s1_valid_r && q_full)
    else $error("front stalled without cause");

endmodule

// File: src/uera_queue.sv
// two-entry queue of finished batches between front and divider
module uera_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_push,
  input  uera_pkg::batch_t q_din,
  output logic             q_full,
  input  logic             q_pop,
  output logic             q_empty,
  output uera_pkg::batch_t q_head
);
  import uera_pkg::*;

  batch_t       mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_push, do_pop;

  // status and head
  assign q_full  = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_din;
    end
  end

  // never more entries than slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

endmodule

// File: src/uera_back.sv
// back end: restoring divider for the batch mean and the result register
module uera_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  uera_pkg::batch_t            q_head,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [uera_pkg::DIST_W-1:0] out_mean_distance,
  output logic [uera_pkg::CNT_W-1:0]  out_valid_count,
  output logic [uera_pkg::CNT_W-1:0]  out_error_count,
  output logic                        out_none_valid
);
  import uera_pkg::*;

  localparam int IT_W = $clog2(SUM_W);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(SUM_W - 1);

  div_state_t        state_r, state_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W-1:0]  err_r;
  logic [IT_W-1:0]   it_r, it_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] mean_r;
  logic [CNT_W-1:0]  vcnt_r, ecnt_r;
  logic              none_r;

  logic              job_take, div_step, out_load, out_take;
  logic [CNT_W:0]    shifted, diff;
  logic              ge;

  // one quotient bit per cycle
  always_comb begin
    shifted = {rem_r, quo_r[SUM_W-1]};
    diff    = shifted - {1'b0, div_r};
    ge      = (shifted >= {1'b0, div_r});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_DIV;
      ST_DIV:  if (it_r == IT_LAST) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_pop) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    job_take = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: job_take = !q_empty;
      ST_DIV:  div_step = 1'b1;
      ST_DONE: out_load = !out_valid_r || out_pop;
      default: ;
    endcase
  end

  assign q_pop    = job_take;
  assign out_take = out_pop && out_valid_r;

  // divider datapath next values
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    it_nxt  = it_r;
    if (job_take) begin
      quo_nxt = q_head.sum;
      rem_nxt = '0;
      it_nxt  = '0;
    end else if (div_step) begin
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      rem_nxt = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      it_nxt  = it_r + IT_W'(1);
    end
  end

  // result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // divider payload
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (job_take) begin
      div_r <= q_head.valid_cnt;
      err_r <= q_head.err_cnt;
    end
  end

  // result payload, zero mean when no sample passed
  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_r <= (div_r == '0) ? '0 : quo_r[DIST_W-1:0];
      vcnt_r <= div_r;
      ecnt_r <= err_r;
      none_r <= (div_r == '0);
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_mean_distance = mean_r;
  assign out_valid_count   = vcnt_r;
  assign out_error_count   = ecnt_r;
  assign out_none_valid    = none_r;

  // the last quotient bit leads to the result handoff
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (it_r == IT_LAST) |=> state_r == ST_DONE)
    else $error("divider did not finish after last bit");

  // a loaded result is shown in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> !out_empty)
    else $error("loaded result not visible");

endmodule

// File: src/ultrasonic_echo_range_averager_top.sv
// top level of the ultrasonic echo range averager
//
// Input channel: one echo beat per push (in_echo_width in microseconds,
// in_echo_seen low on timeout), taken when in_push is high and in_full low.
// Each beat is scaled to a distance in 1/256 cm, range checked, offset
// adjusted and folded into the current batch. After sample_count beats (one if
// sample_count is zero) a batch closes and its mean is computed.
// Result channel: one beat per batch (mean, valid and error counts, no-valid
// flag), shown while out_empty is low and taken with out_pop.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// write only while the block is idle.
// Throughput: the front takes one sample per cycle while in_full is low.
// The divider works on one batch at a time (one load step, 26 quotient
// bits, one handoff), so batches closing faster than it finishes them
// fill the two-entry batch queue and then hold in_full high.
// Reset clears the batch counters, queue, divider and result register and
// restores the configuration defaults. A stalled result receiver holds
// the result register and divider; the queue and front keep working until full.
module ultrasonic_echo_range_averager_top #(
  parameter int ECHO_WIDTH_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ECHO_WIDTH_BITS-1:0]          in_echo_width,
  input  logic                                in_echo_seen,
  input  logic                                in_push,
  output logic                                in_full,
  output logic [uera_pkg::DIST_W-1:0]         out_mean_distance,
  output logic [uera_pkg::CNT_W-1:0]          out_valid_count,
  output logic [uera_pkg::CNT_W-1:0]          out_error_count,
  output logic                                out_none_valid,
  output logic                                out_empty,
  input  logic                                out_pop,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [uera_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [uera_pkg::DIST_W-1:0]         cfg_data
);
  import uera_pkg::*;

  logic [CNT_W-1:0]  sample_count_r, sample_count_nxt;
  logic [DIST_W-1:0] min_distance_r, min_distance_nxt;
  logic [DIST_W-1:0] max_distance_r, max_distance_nxt;
  logic [DIST_W-1:0] offset_distance_r, offset_distance_nxt;

  batch_t batch, q_head;
  logic   batch_push, q_full, q_empty, q_pop;

  // configuration register writes
  assign cfg_ready = 1'b1;

  always_comb begin
    sample_count_nxt    = sample_count_r;
    min_distance_nxt    = min_distance_r;
    max_distance_nxt    = max_distance_r;
    offset_distance_nxt = offset_distance_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SAMPLE_COUNT:    sample_count_nxt    = cfg_data[CNT_W-1:0];
        CFG_MIN_DISTANCE:    min_distance_nxt    = cfg_data;
        CFG_MAX_DISTANCE:    max_distance_nxt    = cfg_data;
        CFG_OFFSET_DISTANCE: offset_distance_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r    <= RST_SAMPLE_COUNT;
      min_distance_r    <= RST_MIN_DISTANCE;
      max_distance_r    <= RST_MAX_DISTANCE;
      offset_distance_r <= RST_OFFSET_DISTANCE;
    end else begin
      sample_count_r    <= sample_count_nxt;
      min_distance_r    <= min_distance_nxt;
      max_distance_r    <= max_distance_nxt;
      offset_distance_r <= offset_distance_nxt;
    end
  end

  // sample front end
  uera_front #(
    .ECHO_WIDTH_BITS (ECHO_WIDTH_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_echo_width   (in_echo_width),
    .in_echo_seen    (in_echo_seen),
    .in_push         (in_push),
    .in_full         (in_full),
    .sample_count    (sample_count_r),
    .min_distance    (min_distance_r),
    .max_distance    (max_distance_r),
    .offset_distance (offset_distance_r),
    .batch           (batch),
    .batch_push      (batch_push),
    .q_full          (q_full)
  );

  // batch queue
  uera_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (batch_push),
    .q_din   (batch),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // mean divider and result register
  uera_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_mean_distance (out_mean_distance),
    .out_valid_count   (out_valid_count),
    .out_error_count   (out_error_count),
    .out_none_valid    (out_none_valid)
  );

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the ultrasonic echo range averager
`timescale 1ns / 100ps

module tb_top;
  import uera_pkg::*;

  localparam int ECHO_W        = 15;
  localparam int N_RANDOM      = 1000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;

  // one batch result as it leaves the block
  typedef struct packed {
    logic [DIST_W-1:0] mean;
    logic [CNT_W-1:0]  valid;
    logic [CNT_W-1:0]  errs;
    logic              none;
  } echo_result_t;

  // directed stimulus rows
  typedef enum logic [1:0] {
    ROW_ECHO,
    ROW_ECHO_CHK,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    cfg_reg_t          idx;
    logic [DIST_W-1:0] val;
    logic [ECHO_W-1:0] width;
    logic              seen;
    echo_result_t      want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [ECHO_W-1:0]   in_echo_width = '0;
  logic                in_echo_seen = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic [DIST_W-1:0]   out_mean_distance;
  logic [CNT_W-1:0]    out_valid_count;
  logic [CNT_W-1:0]    out_error_count;
  logic                out_none_valid;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIST_W-1:0]   cfg_data = '0;

  // predictor copy of configuration and batch state
  logic [CNT_W-1:0]    samples_per_batch;
  logic [DIST_W-1:0]   range_min;
  logic [DIST_W-1:0]   range_max;
  logic [DIST_W-1:0]   range_offset;
  logic [SUM_W-1:0]    batch_sum;
  logic [CNT_W-1:0]    batch_taken;
  logic [CNT_W-1:0]    batch_errors;

  echo_result_t        batch_results_due[$];
  echo_result_t        seen_result;
  echo_result_t        due_result;
  row_t                directed_rows[$];
  bit                  hold_off_req = 1'b0;
  int                  n_fail = 0;
  int                  stall_cycles = 0;

  ultrasonic_echo_range_averager_top #(
    .ECHO_WIDTH_BITS(ECHO_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_echo_width    (in_echo_width),
    .in_echo_seen     (in_echo_seen),
    .in_push          (in_push),
    .in_full          (in_full),
    .out_mean_distance(out_mean_distance),
    .out_valid_count  (out_valid_count),
    .out_error_count  (out_error_count),
    .out_none_valid   (out_none_valid),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // fold one echo into the batch, report whether it closes the batch
  task automatic fold_echo(input logic [ECHO_W-1:0] width, input logic seen,
                           output bit closes, output echo_result_t res);
    logic [31:0]      half_w;
    logic [31:0]      dist_v;
    logic [31:0]      adj;
    logic [CNT_W-1:0] valid;
    logic [SUM_W-1:0] quot;
    bit               ok;
    half_w = width >> 1;
    dist_v = (half_w * SPEED_FACTOR) >> SPEED_SHIFT;
    ok     = seen && dist_v >= range_min && dist_v <= range_max;
    if (ok && range_offset != 0) begin
      ok = dist_v > range_offset;
    end
    adj = (range_offset != 0) ? dist_v - range_offset : dist_v;
    if (ok) begin
      batch_sum = batch_sum + adj[SUM_W-1:0];
    end else begin
      batch_errors = batch_errors + 1'b1;
    end
    batch_taken = batch_taken + 1'b1;
    closes = !(batch_taken < samples_per_batch && batch_taken != 0);
    res = '0;
    if (closes) begin
      valid = batch_taken - batch_errors;
      quot  = (valid != 0) ? batch_sum / valid : '0;
      res.mean  = quot[DIST_W-1:0];
      res.valid = valid;
      res.errs  = batch_errors;
      res.none  = (valid == 0);
      batch_sum    = '0;
      batch_taken  = '0;
      batch_errors = '0;
    end
  endtask

  // offer one echo beat and hold it until taken
  task automatic push_sample(input logic [ECHO_W-1:0] width, input logic seen,
                             input bit typed, input echo_result_t typed_res);
    bit           closes;
    echo_result_t res;
    @(negedge clk);
    in_echo_width <= width;
    in_echo_seen  <= seen;
    in_push       <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    fold_echo(width, seen, closes, res);
    if (closes) begin
      batch_results_due.push_back(typed ? typed_res : res);
    end
  endtask

  // input gap with noise on the data lines
  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_push       <= 1'b0;
      in_echo_width <= ECHO_W'($urandom);
      in_echo_seen  <= 1'($urandom);
    end
  endtask

  // stop offering, wait for every due result and for the divider to go quiet
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (batch_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one configuration beat
  task automatic write_reg(input cfg_reg_t idx, input logic [DIST_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SAMPLE_COUNT:    samples_per_batch = data[CNT_W-1:0];
      CFG_MIN_DISTANCE:    range_min = data;
      CFG_MAX_DISTANCE:    range_max = data;
      CFG_OFFSET_DISTANCE: range_offset = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // directed row builders
  function automatic row_t echo_row(input logic [ECHO_W-1:0] width, input bit seen);
    row_t r;
    r = '0;
    r.kind  = ROW_ECHO;
    r.width = width;
    r.seen  = seen;
    return r;
  endfunction

  function automatic row_t chk_row(input logic [ECHO_W-1:0] width, input bit seen,
                                   input logic [DIST_W-1:0] mean,
                                   input logic [CNT_W-1:0] valid,
                                   input logic [CNT_W-1:0] errs, input bit none);
    row_t r;
    r = echo_row(width, seen);
    r.kind       = ROW_ECHO_CHK;
    r.want.mean  = mean;
    r.want.valid = valid;
    r.want.errs  = errs;
    r.want.none  = none;
    return r;
  endfunction

  function automatic row_t cfg_row(input cfg_reg_t idx, input logic [DIST_W-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      seen_result = '{out_mean_distance, out_valid_count, out_error_count, out_none_valid};
      if (batch_results_due.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
          $display("unexpected result beat: mean %0d valid %0d errors %0d none %0d",
                   seen_result.mean, seen_result.valid, seen_result.errs,
                   seen_result.none);
        end
      end else begin
        due_result = batch_results_due.pop_front();
        if (seen_result.mean !== due_result.mean || seen_result.valid !== due_result.valid ||
            seen_result.errs !== due_result.errs || seen_result.none !== due_result.none) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("result mismatch: mean %0d/%0d valid %0d/%0d errors %0d/%0d none %0d/%0d",
                     due_result.mean, seen_result.mean, due_result.valid, seen_result.valid,
                     due_result.errs, seen_result.errs, due_result.none, seen_result.none);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result receiver: stall pattern in windows, plus one long hold-off on request
  initial begin
    int cyc;
    int mode;
    int k;
    cyc  = 0;
    mode = 0;
    forever begin
      if (hold_off_req) begin
        for (k = 0; k < HOLD_CYCLES; k++) begin
          @(negedge clk);
          out_pop <= 1'b0;
        end
        hold_off_req = 1'b0;
      end else begin
        @(negedge clk);
        if (cyc % 64 == 0) begin
          mode = $urandom_range(0, 3);
        end
        case (mode)
          0: out_pop <= 1'b1;
          1: out_pop <= 1'($urandom_range(0, 1));
          2: out_pop <= ($urandom_range(0, 3) == 0);
          default: out_pop <= (cyc % 16) < 8;
        endcase
        cyc++;
      end
    end
  end

  // stimulus
  initial begin
    int           sent;
    int           phase;
    int           n_items;
    int           burst_left;
    int           cnt;
    bit           big_done;
    row_t         r;
    logic [DIST_W-1:0] cnt_data;
    echo_result_t no_res;

    no_res = '0;
    samples_per_batch = RST_SAMPLE_COUNT;
    range_min         = RST_MIN_DISTANCE;
    range_max         = RST_MAX_DISTANCE;
    range_offset      = RST_OFFSET_DISTANCE;
    batch_sum         = '0;
    batch_taken       = '0;
    batch_errors      = '0;

    // reset
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // reset settings: every sample closes a batch
    directed_rows.push_back(chk_row(0, 1, 0, 0, 1, 1));
    directed_rows.push_back(chk_row(32767, 1, 143863, 1, 0, 0));
    directed_rows.push_back(chk_row(32767, 0, 0, 0, 1, 1));
    directed_rows.push_back(chk_row(0, 0, 0, 0, 1, 1));
    // just under and just over the minimum range, odd width truncation
    directed_rows.push_back(chk_row(1166, 1, 0, 0, 1, 1));
    directed_rows.push_back(chk_row(1168, 1, 5128, 1, 0, 0));
    directed_rows.push_back(echo_row(1167, 1));
    // exactly at and just over the maximum range
    directed_rows.push_back(cfg_row(CFG_MAX_DISTANCE, 100000));
    directed_rows.push_back(chk_row(22776, 1, 100000, 1, 0, 0));
    directed_rows.push_back(chk_row(22778, 1, 0, 0, 1, 1));
    // offset equal to distance is rejected, larger distance is reduced
    directed_rows.push_back(cfg_row(CFG_OFFSET_DISTANCE, 100000));
    directed_rows.push_back(chk_row(22776, 1, 0, 0, 1, 1));
    directed_rows.push_back(cfg_row(CFG_MAX_DISTANCE, 262143));
    directed_rows.push_back(echo_row(32767, 1));
    // zero distance accepted with open range
    directed_rows.push_back(cfg_row(CFG_MIN_DISTANCE, 0));
    directed_rows.push_back(cfg_row(CFG_OFFSET_DISTANCE, 0));
    directed_rows.push_back(chk_row(0, 1, 0, 1, 0, 0));
    // inverted range limits reject everything
    directed_rows.push_back(cfg_row(CFG_MIN_DISTANCE, 200000));
    directed_rows.push_back(cfg_row(CFG_MAX_DISTANCE, 100));
    directed_rows.push_back(chk_row(20000, 1, 0, 0, 1, 1));
    directed_rows.push_back(cfg_row(CFG_MIN_DISTANCE, 5120));
    directed_rows.push_back(cfg_row(CFG_MAX_DISTANCE, 153600));
    // mixed batch of four
    directed_rows.push_back(cfg_row(CFG_SAMPLE_COUNT, 4));
    directed_rows.push_back(echo_row(32767, 1));
    directed_rows.push_back(echo_row(5000, 1));
    directed_rows.push_back(echo_row(0, 0));
    directed_rows.push_back(echo_row(12000, 1));
    // batch size lowered below the samples already taken
    directed_rows.push_back(cfg_row(CFG_SAMPLE_COUNT, 10));
    directed_rows.push_back(echo_row(3000, 1));
    directed_rows.push_back(echo_row(7000, 1));
    directed_rows.push_back(echo_row(100, 1));
    directed_rows.push_back(echo_row(15000, 0));
    directed_rows.push_back(echo_row(30000, 1));
    directed_rows.push_back(cfg_row(CFG_SAMPLE_COUNT, 3));
    directed_rows.push_back(echo_row(9000, 1));
    // zero batch size acts as one
    directed_rows.push_back(cfg_row(CFG_SAMPLE_COUNT, 0));
    directed_rows.push_back(echo_row(9000, 1));

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_CFG) begin
        settle();
        write_reg(r.idx, r.val);
      end else begin
        push_sample(r.width, r.seen, r.kind == ROW_ECHO_CHK, r.want);
      end
    end

    // random phases, each with its own settings
    sent     = 0;
    phase    = 0;
    big_done = 1'b0;
    while (sent < N_RANDOM) begin
      settle();
      case ($urandom_range(0, 7))
        0, 1, 2: cnt = $urandom_range(1, 6);
        3:       cnt = 1;
        4:       cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(7, 40);
        5:       cnt = (!big_done && phase > 4) ? 255 : $urandom_range(1, 20);
        default: cnt = $urandom_range(2, 12);
      endcase
      if (phase == 2) begin
        cnt = 1;
      end
      if (cnt == 255) begin
        big_done = 1'b1;
      end
      cnt_data = $urandom_range(0, 3) == 0 ? DIST_W'($urandom) : '0;
      cnt_data[CNT_W-1:0] = CNT_W'(cnt);
      write_reg(CFG_SAMPLE_COUNT, cnt_data);
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_MIN_DISTANCE, 0);
        1, 2:    write_reg(CFG_MIN_DISTANCE, DIST_W'($urandom_range(0, 20000)));
        default: write_reg(CFG_MIN_DISTANCE, DIST_W'($urandom_range(0, 262143)));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_MAX_DISTANCE, 262143);
        1, 2:    write_reg(CFG_MAX_DISTANCE, DIST_W'($urandom_range(100000, 262143)));
        default: write_reg(CFG_MAX_DISTANCE, DIST_W'($urandom_range(0, 262143)));
      endcase
      case ($urandom_range(0, 5))
        0, 1, 2: write_reg(CFG_OFFSET_DISTANCE, 0);
        3, 4:    write_reg(CFG_OFFSET_DISTANCE, DIST_W'($urandom_range(1, 60000)));
        default: write_reg(CFG_OFFSET_DISTANCE, DIST_W'($urandom_range(0, 262143)));
      endcase

      n_items = (cnt == 255) ? 255 + $urandom_range(0, 40) : $urandom_range(20, 80);
      // long receiver hold-off while the sender keeps offering
      if (phase == 2) begin
        hold_off_req = 1'b1;
        n_items      = 40;
      end

      burst_left = 0;
      repeat (n_items) begin
        if (burst_left == 0) begin
          case ($urandom_range(0, 3))
            0:       idle_input(0);
            1, 2:    idle_input($urandom_range(1, 6));
            default: idle_input($urandom_range(7, 40));
          endcase
          burst_left = $urandom_range(1, 24);
        end
        push_sample(ECHO_W'($urandom), $urandom_range(0, 9) != 0, 1'b0, no_res);
        burst_left--;
        sent++;
      end
      phase++;
    end

    // drain and finish
    settle();
    n_fail += batch_results_due.size();
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
src/uera_pkg.sv
src/uera_front.sv
src/uera_queue.sv
src/uera_back.sv
src/ultrasonic_echo_range_averager_top.sv
tb/tb_top.sv
